// ===== rtl/hspu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the helper function of the scan line pixel unpacker.
package hspu_pkg;

    localparam int CHANNELS_DEFAULT     = 6;
    localparam int HEADER_BYTES_DEFAULT = 50;

    localparam int CHAN_BYTES      = 5;
    localparam int PIX_PER_GROUP   = 4;
    localparam int GROUPS_PER_LINE = 385;
    localparam int LAST_PIXEL      = GROUPS_PER_LINE * PIX_PER_GROUP - 1;
    localparam int SYNC_LEN        = 8;
    localparam int SYNC_IDX_W      = $clog2(SYNC_LEN);

    localparam int POS_W      = 14;
    localparam int GCOUNT_W   = 9;
    localparam int SAMPLE_W   = $clog2(PIX_PER_GROUP);
    localparam int INDEX_W    = GCOUNT_W + SAMPLE_W;
    localparam int GRAY_W     = 3;
    localparam int CFG_DATA_W = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{
        8'h02, 8'h18, 8'hA7, 8'hA3, 8'h92, 8'hDD, 8'h9A, 8'hBF
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_MODE   = 1'b0,
        REG_GRAY_CHANNEL = 1'b1
    } cfg_reg_t;

    localparam logic COLOR_GRAY = 1'b0;
    localparam logic COLOR_RGB  = 1'b1;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_t;

    // One finished group: four pixels ready to send, plus line position and sync status.
    typedef struct packed {
        rgb_t [PIX_PER_GROUP-1:0] pix;
        logic [GCOUNT_W-1:0]      group_num;
        logic                     sync_ok;
    } group_t;

    // Pixel 'sample' of a 5-byte channel spans bytes sample and sample+1, MSB first.
    // The 10-bit value is reduced to 8 bits by dropping its two low bits.
    function automatic pix_t pixel8(input pix_t hi, input pix_t lo,
                                    input logic [SAMPLE_W-1:0] sample);
        logic [15:0] word;
        pix_t        result;
        word = {hi, lo};
        unique case (sample)
            2'd0: result = word[15:8];
            2'd1: result = word[13:6];
            2'd2: result = word[11:4];
            2'd3: result = word[9:2];
        endcase
        return result;
    endfunction

endpackage

// ===== rtl/hrpt_scan_pixel_unpacker_core.sv =====
`timescale 1ns / 1ps
// Top level of the scan line pixel unpacker: configuration registers and the two stages.
//
// The input channel takes one image byte per word, with start_of_scan marking byte 0 of
// a scan line; a word is taken when in_valid is high and in_stall is low. Bytes 0 to 7
// are checked against the sync word, the header bytes are skipped, and each
// following group of five bytes per channel is collected in a shift line. The byte that
// closes a group loads four finished pixels into a capture register, and the output
// channel then presents them one after another (out_valid / out_stall).
//
// Throughput is one input word per cycle while in_stall is low. The first pixel of a
// group passes through the capture register and then the output register. in_stall
// rises only while the next group's closing byte is due and the previous group still
// has pixels waiting, which happens only if the receiver holds out_stall for most of
// a group; while stalled, the output word holds steady. Configuration is sampled when
// a group closes.
//
// Reset (rst_n low, asynchronous) clears the byte position, group count and all valid
// flags and sets the sync flag; the first byte after reset counts as byte 0 even without
// a start flag. Both configuration registers reset to zero: gray mode from channel 0.
module hrpt_scan_pixel_unpacker_core
    import hspu_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEFAULT,
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_scan,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic                  last_of_line,
    output logic                  sync_ok
);

    logic              color_mode_reg;
    logic [GRAY_W-1:0] gray_channel_reg;
    logic              grp_valid;
    logic              grp_take;
    group_t            grp;

    // Plain write port; the two registers decode from the single index bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= COLOR_GRAY;
            gray_channel_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                REG_GRAY_CHANNEL: gray_channel_reg <= cfg_data[GRAY_W-1:0];
            endcase
        end
    end

    hspu_front #(
        .CHANNELS     (CHANNELS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_of_scan (start_of_scan),
        .color_mode    (color_mode_reg),
        .gray_channel  (gray_channel_reg),
        .grp_valid     (grp_valid),
        .grp           (grp),
        .grp_take      (grp_take)
    );

    hspu_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp_valid    (grp_valid),
        .grp          (grp),
        .grp_take     (grp_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pixel_index  (pixel_index),
        .last_of_line (last_of_line),
        .sync_ok      (sync_ok)
    );

endmodule

// ===== rtl/hspu_front.sv =====
`timescale 1ns / 1ps
// Byte tracking, sync check, group shift line and group capture register.
module hspu_front
    import hspu_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEFAULT,
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              start_of_scan,
    input  logic              color_mode,
    input  logic [GRAY_W-1:0] gray_channel,
    output logic              grp_valid,
    output group_t            grp,
    input  logic              grp_take
);

    localparam int GROUP_BYTES = CHAN_BYTES * CHANNELS;
    localparam int OFF_W       = $clog2(GROUP_BYTES);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(GROUP_BYTES - 1);
    localparam logic [POS_W-1:0] POS_MAX  = '1;

    logic [POS_W-1:0]    pos_reg, pos_next, pos_cur;
    logic                sync_reg, sync_next, sync_cur;
    logic [GCOUNT_W-1:0] gcount_reg, gcount_next, gcount_cur;
    logic [OFF_W-1:0]    off_reg, off_next, off_cur;
    logic                grp_valid_reg, grp_valid_next;
    group_t              grp_reg, grp_new;

    logic [7:0] shift_reg [GROUP_BYTES-1];
    logic [7:0] gb [GROUP_BYTES];
    logic [7:0] chan_bytes [CHANNELS][CHAN_BYTES];
    logic [7:0] gray_bytes [CHAN_BYTES];
    logic [CH_W-1:0] ch_sel;

    logic accept, shift_en, group_end;

    // Only the byte that closes a group needs the capture register, so stall just that one.
    assign in_stall = grp_valid_reg && (off_reg == OFF_LAST);
    assign accept   = in_valid && !in_stall;

    assign pos_cur    = start_of_scan ? '0 : pos_reg;
    assign sync_cur   = start_of_scan ? 1'b1 : sync_reg;
    assign gcount_cur = start_of_scan ? '0 : gcount_reg;
    assign off_cur    = start_of_scan ? '0 : off_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        sync_next   = sync_reg;
        gcount_next = gcount_reg;
        off_next    = off_reg;
        shift_en    = 1'b0;
        group_end   = 1'b0;
        if (accept)
        begin
            pos_next    = (pos_cur < POS_MAX) ? pos_cur + POS_W'(1) : pos_cur;
            sync_next   = sync_cur;
            gcount_next = gcount_cur;
            off_next    = off_cur;
            if (pos_cur < POS_W'(SYNC_LEN) && data_byte != SYNC_WORD[pos_cur[SYNC_IDX_W-1:0]])
            begin
                sync_next = 1'b0;
            end
            if (pos_cur >= POS_W'(HEADER_BYTES) && gcount_cur < GCOUNT_W'(GROUPS_PER_LINE))
            begin
                shift_en = 1'b1;
                if (off_cur == OFF_LAST)
                begin
                    group_end   = 1'b1;
                    off_next    = '0;
                    gcount_next = gcount_cur + GCOUNT_W'(1);
                end
                else
                begin
                    off_next = off_cur + OFF_W'(1);
                end
            end
        end
    end

    // The whole group as it stands once the closing byte arrives.
    always_comb
    begin
        for (int k = 0; k < GROUP_BYTES - 1; k++)
        begin
            gb[k] = shift_reg[k];
        end
        gb[GROUP_BYTES-1] = data_byte;
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int i = 0; i < CHAN_BYTES; i++)
            begin
                chan_bytes[c][i] = gb[c*CHAN_BYTES + i];
            end
        end
    end

    always_comb
    begin
        if ({1'b0, gray_channel} >= (GRAY_W + 1)'(CHANNELS))
        begin
            ch_sel = CH_W'(CHANNELS - 1);
        end
        else
        begin
            ch_sel = gray_channel[CH_W-1:0];
        end
        for (int i = 0; i < CHAN_BYTES; i++)
        begin
            gray_bytes[i] = chan_bytes[ch_sel][i];
        end
    end

    always_comb
    begin
        grp_new.group_num = gcount_cur;
        grp_new.sync_ok   = sync_next;
        for (int j = 0; j < PIX_PER_GROUP; j++)
        begin
            if (color_mode == COLOR_RGB)
            begin
                grp_new.pix[j].red   = pixel8(chan_bytes[2][j], chan_bytes[2][j+1],
                                              SAMPLE_W'(j));
                grp_new.pix[j].green = pixel8(chan_bytes[1][j], chan_bytes[1][j+1],
                                              SAMPLE_W'(j));
                grp_new.pix[j].blue  = pixel8(chan_bytes[0][j], chan_bytes[0][j+1],
                                              SAMPLE_W'(j));
            end
            else
            begin
                grp_new.pix[j].red   = pixel8(gray_bytes[j], gray_bytes[j+1], SAMPLE_W'(j));
                grp_new.pix[j].green = grp_new.pix[j].red;
                grp_new.pix[j].blue  = grp_new.pix[j].red;
            end
        end
    end

    assign grp_valid_next = group_end || (grp_valid_reg && !grp_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sync_reg      <= 1'b1;
            gcount_reg    <= '0;
            off_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sync_reg      <= sync_next;
            gcount_reg    <= gcount_next;
            off_reg       <= off_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int k = 0; k < GROUP_BYTES - 2; k++)
            begin
                shift_reg[k] <= shift_reg[k+1];
            end
            shift_reg[GROUP_BYTES-2] <= data_byte;
        end
        if (group_end)
        begin
            grp_reg <= grp_new;
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

endmodule

// ===== rtl/hspu_emit.sv =====
`timescale 1ns / 1ps
// Sends the four pixels of a captured group through the output register.
module hspu_emit
    import hspu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_valid,
    input  group_t             grp,
    output logic               grp_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [INDEX_W-1:0] pixel_index,
    output logic               last_of_line,
    output logic               sync_ok
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [INDEX_W-1:0]  index_new;
    logic [7:0]          red_reg, green_reg, blue_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                last_reg, sync_reg;

    assign out_load       = grp_valid && (!out_valid_reg || !out_stall);
    assign grp_take       = out_load && (sample_reg == SAMPLE_W'(PIX_PER_GROUP - 1));
    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign index_new      = {grp.group_num, sample_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                sample_reg <= sample_reg + SAMPLE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= grp.pix[sample_reg].red;
            green_reg <= grp.pix[sample_reg].green;
            blue_reg  <= grp.pix[sample_reg].blue;
            index_reg <= index_new;
            last_reg  <= (index_new == INDEX_W'(LAST_PIXEL));
            sync_reg  <= grp.sync_ok;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign pixel_index  = index_reg;
    assign last_of_line = last_reg;
    assign sync_ok      = sync_reg;

endmodule

// ===== rtl/hspu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the output channel of the unpacker, bound to the top level.
module hspu_checker
    import hspu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         red,
    input logic [7:0]         green,
    input logic [7:0]         blue,
    input logic [INDEX_W-1:0] pixel_index,
    input logic               last_of_line,
    input logic               sync_ok
);

    // A stalled output word stays put.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(red)
            && $stable(green) && $stable(blue) && $stable(sync_ok))
        else $error("output word changed while stalled");

    // Pixel columns never run past the end of the line.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_index <= INDEX_W'(LAST_PIXEL))
        else $error("pixel index beyond end of line");

    // The end-of-line flag marks exactly the final column.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_of_line == (pixel_index == INDEX_W'(LAST_PIXEL)))
        else $error("last_of_line does not match pixel index");

    // Within a group the four pixels follow back to back with one sync status.
    a_group_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && pixel_index[SAMPLE_W-1:0] != SAMPLE_W'(PIX_PER_GROUP - 1)
            |=> out_valid && pixel_index == $past(pixel_index) + INDEX_W'(1)
                && sync_ok == $past(sync_ok))
        else $error("pixels of one group not sent back to back");

endmodule

bind hrpt_scan_pixel_unpacker_core hspu_checker u_hspu_checker (.*);
